>>> sv/mexp_pkg.sv
// Shared constants and control types for the modular exponentiation block.
package mexp_pkg;

  // Default operand width
  localparam int VALUE_BITS_DEF = 20;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd1;

  // Modular multiplier operation: selects operands and destination
  typedef enum logic [1:0] {
    OP_RED = 2'd0,  // base * 1 mod m, reduces the base into range
    OP_MUL = 2'd1,  // acc * sq mod m
    OP_SQR = 2'd2   // sq * sq mod m
  } mm_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic   capture;   // latch input word and start the base reduction
    logic   mm_start;  // start a modular multiply
    mm_op_t op;        // operation for mm_start
    logic   out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mm_busy;   // modular multiplier is running
    logic ex_zero;   // no exponent bits left
    logic ex_bit0;   // current exponent bit
  } dp_status_t;

endpackage

>>> sv/mexp_if.sv
// Valid/ready channel interfaces for input and result words.
interface mexp_in_if #(
  parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] base_value;
  logic                  last_in;

  modport source (output valid, output base_value, output last_in, input ready);
  modport sink   (input valid, input base_value, input last_in, output ready);
endinterface

interface mexp_out_if #(
  parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] power_result;
  logic                  last_out;

  modport source (output valid, output power_result, output last_out, input ready);
  modport sink   (input valid, input power_result, input last_out, output ready);
endinterface

>>> sv/modular_exponentiation_top.sv
// Top level of the modular exponentiation block.
// Each input word is raised to the exponent register and reduced modulo the modulus
// register; last_in travels along as last_out. One word is worked on at a time, and a
// finished result waits in an output register while the next word is taken in. All
// arithmetic runs through one bit-serial modular multiplier that handles one multiplier
// bit per cycle. Write the registers only while idle. The modulus register saturates
// at 2 and resets to 2; the exponent resets to 1.
module modular_exponentiation_top #(
  parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]             cfg_data,
  mexp_in_if.sink                           in_word,
  mexp_out_if.source                        out_word
);

  mexp_pkg::ctrl_cmd_t  cmd;
  mexp_pkg::dp_status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .base_value   (in_word.base_value),
    .last_in      (in_word.last_in),
    .cmd          (cmd),
    .status       (status),
    .power_result (out_word.power_result),
    .last_out     (out_word.last_out)
  );

endmodule

>>> sv/mexp_dp.sv
// Datapath: config registers, bit-serial modular multiplier, exponent state, output register.
module mexp_dp #(
  parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]             cfg_data,
  input  logic [VALUE_BITS-1:0]             base_value,
  input  logic                              last_in,
  input  mexp_pkg::ctrl_cmd_t               cmd,
  output mexp_pkg::dp_status_t              status,
  output logic [VALUE_BITS-1:0]             power_result,
  output logic                              last_out
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] TWO = VALUE_BITS'(2);

  // Configuration
  logic [VALUE_BITS-1:0] exp_r;
  logic [VALUE_BITS-1:0] mod_r;

  // Exponentiation state
  logic [VALUE_BITS-1:0] ex_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic [VALUE_BITS-1:0] sq_r;
  logic                  last_r;

  // Modular multiplier state
  logic                  mm_busy_r;
  mexp_pkg::mm_op_t      mm_op_r;
  logic [VALUE_BITS-1:0] mm_a_r;
  logic [VALUE_BITS-1:0] mm_b_r;
  logic [VALUE_BITS-1:0] mm_acc_r;
  logic [CW-1:0]         mm_cnt_r;

  // Output register
  logic [VALUE_BITS-1:0] res_r;
  logic                  last_out_r;

  logic [VALUE_BITS:0]   mod_w;
  logic [VALUE_BITS:0]   dbl;
  logic [VALUE_BITS:0]   dbl_red;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS:0]   sum_red;
  logic [VALUE_BITS-1:0] mm_acc_nxt;
  logic                  mm_last;

  // One multiplier bit: acc = 2*acc mod m, then add a mod m if the b bit is set
  always_comb begin
    mod_w   = {1'b0, mod_r};
    dbl     = {mm_acc_r, 1'b0};
    dbl_red = (dbl >= mod_w) ? (dbl - mod_w) : dbl;
    sum     = dbl_red + {1'b0, mm_a_r};
    sum_red = (sum >= mod_w) ? (sum - mod_w) : sum;
    if (mm_b_r[VALUE_BITS-1]) begin
      mm_acc_nxt = sum_red[VALUE_BITS-1:0];
    end else begin
      mm_acc_nxt = dbl_red[VALUE_BITS-1:0];
    end
    mm_last = (mm_cnt_r == '0);
  end

  // Config writes; modulus saturates at two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= ONE;
      mod_r <= TWO;
    end else if (cfg_we) begin
      case (cfg_index)
        mexp_pkg::REG_EXPONENT: exp_r <= cfg_data;
        mexp_pkg::REG_MODULUS:  mod_r <= (cfg_data < TWO) ? TWO : cfg_data;
        default: ;
      endcase
    end
  end

  // Multiplier sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_busy_r <= 1'b0;
    end else if (cmd.capture || cmd.mm_start) begin
      mm_busy_r <= 1'b1;
    end else if (mm_busy_r && mm_last) begin
      mm_busy_r <= 1'b0;
    end
  end

  // Multiplier operands and partial product
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mm_op_r  <= mexp_pkg::OP_RED;
      mm_a_r   <= ONE;
      mm_b_r   <= base_value;
      mm_acc_r <= '0;
      mm_cnt_r <= CW'(VALUE_BITS - 1);
    end else if (cmd.mm_start) begin
      mm_op_r  <= cmd.op;
      mm_a_r   <= (cmd.op == mexp_pkg::OP_MUL) ? acc_r : sq_r;
      mm_b_r   <= sq_r;
      mm_acc_r <= '0;
      mm_cnt_r <= CW'(VALUE_BITS - 1);
    end else if (mm_busy_r) begin
      mm_b_r   <= {mm_b_r[VALUE_BITS-2:0], 1'b0};
      mm_acc_r <= mm_acc_nxt;
      mm_cnt_r <= mm_cnt_r - CW'(1);
    end
  end

  // Exponent state and product writeback
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ex_r   <= exp_r;
      acc_r  <= ONE;
      last_r <= last_in;
    end else if (mm_busy_r && mm_last) begin
      case (mm_op_r)
        mexp_pkg::OP_RED: sq_r <= mm_acc_nxt;
        mexp_pkg::OP_MUL: acc_r <= mm_acc_nxt;
        mexp_pkg::OP_SQR: begin
          sq_r <= mm_acc_nxt;
          ex_r <= {1'b0, ex_r[VALUE_BITS-1:1]};
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r      <= acc_r;
      last_out_r <= last_r;
    end
  end

  assign status.mm_busy = mm_busy_r;
  assign status.ex_zero = (ex_r == '0);
  assign status.ex_bit0 = ex_r[0];
  assign power_result   = res_r;
  assign last_out       = last_out_r;

endmodule

>>> sv/mexp_ctrl.sv
// Controller: sequences reduction, multiplies and squarings, and runs both handshakes.
module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RED   = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_SQR   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.mm_start = 1'b0;
    cmd.op       = mexp_pkg::OP_SQR;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RED;
        end
      end
      ST_RED: begin
        if (!status.mm_busy) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.ex_zero) begin
          state_nxt = ST_FIN;
        end else if (status.ex_bit0) begin
          cmd.mm_start = 1'b1;
          cmd.op       = mexp_pkg::OP_MUL;
          state_nxt    = ST_MUL;
        end else begin
          cmd.mm_start = 1'b1;
          state_nxt    = ST_SQR;
        end
      end
      ST_MUL: begin
        // multiply done: square next
        if (!status.mm_busy) begin
          cmd.mm_start = 1'b1;
          state_nxt    = ST_SQR;
        end
      end
      ST_SQR: begin
        if (!status.mm_busy) state_nxt = ST_CHECK;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/mexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top level.
module mexp_checker #(
  parameter int VALUE_BITS = mexp_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] power_result,
  input logic                  last_out
);

  // Result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // Stalled result payload stays put
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(power_result) && $stable(last_out))
    else $error("result word changed while stalled");

  // One word at a time: input closes right after a word is taken
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in progress");

  // Out of reset: idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind modular_exponentiation_top mexp_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_mexp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_word.valid),
  .in_ready     (in_word.ready),
  .out_valid    (out_word.valid),
  .out_ready    (out_word.ready),
  .power_result (out_word.power_result),
  .last_out     (out_word.last_out)
);

>>> tb/modular_exponentiation_top_tb.sv
// Testbench for modular_exponentiation_top: directed and random words checked against a power-mod predictor.
`timescale 1ns / 1ps

module modular_exponentiation_top_tb;

  localparam int VALUE_BITS = mexp_pkg::VALUE_BITS_DEF;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
  // Indexes past the register file; writes there must be dropped
  localparam logic [mexp_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [mexp_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_3 = 2'd3;
  localparam int RANDOM_WORDS = 600;
  localparam int DRAIN_CYCLES = 900;
  localparam int WATCHDOG_LIMIT = 8000;

  typedef struct {
    logic [VALUE_BITS-1:0] power;
    logic                  last;
  } power_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mexp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [VALUE_BITS-1:0] cfg_data;

  mexp_in_if  #(.VALUE_BITS(VALUE_BITS)) in_word ();
  mexp_out_if #(.VALUE_BITS(VALUE_BITS)) out_word ();

  modular_exponentiation_top #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .out_word (out_word)
  );

  // Register copies kept in step with every write
  logic [VALUE_BITS-1:0] exponent_setting;
  logic [VALUE_BITS-1:0] modulus_setting;

  power_word_t pending_powers[$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // base ^ ex mod m by square-and-multiply; 20-bit operands keep products in 64 bits
  function automatic logic [VALUE_BITS-1:0] predict_power(logic [VALUE_BITS-1:0] base,
                                                          logic [VALUE_BITS-1:0] ex,
                                                          logic [VALUE_BITS-1:0] m);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned mm;
    logic [VALUE_BITS-1:0] bits;
    mm = m;
    acc = 1 % mm;
    sq = base % mm;
    bits = ex;
    while (bits != '0) begin
      if (bits[0]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
      bits = bits >> 1;
    end
    return acc[VALUE_BITS-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_BITS-1:0] got,
                                 logic [VALUE_BITS-1:0] want);
    $display("tb: mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  // One register write; the mirror follows the block's saturation and index rules
  task automatic write_reg(logic [mexp_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [VALUE_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mexp_pkg::REG_EXPONENT: exponent_setting = data;
      mexp_pkg::REG_MODULUS:  modulus_setting = (data < VALUE_BITS'(2)) ? VALUE_BITS'(2) : data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one word, with random idle cycles ahead of it, and record its expected result
  task automatic send_word(logic [VALUE_BITS-1:0] base, logic last);
    power_word_t exp_word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid <= 1'b1;
    in_word.base_value <= base;
    in_word.last_in <= last;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    exp_word.power = predict_power(base, exponent_setting, modulus_setting);
    exp_word.last = last;
    pending_powers.insert(pending_powers.size(), exp_word);
  endtask

  // Hold the sender off until every outstanding result is back
  task automatic drain_results();
    in_word.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Result side: random stalls and field checks
  always @(posedge clk) begin
    out_word.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    power_word_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_powers.size() == 0) begin
        report_mismatch("power_result with nothing outstanding", out_word.power_result, '0);
      end else begin
        want = pending_powers.pop_front();
        if (out_word.power_result !== want.power)
          report_mismatch("power_result", out_word.power_result, want.power);
        if (out_word.last_out !== want.last)
          report_mismatch("last_out", VALUE_BITS'(out_word.last_out), VALUE_BITS'(want.last));
      end
    end
  end

  // Watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset values: exponent 1, modulus 2, so the result is the base's low bit
  task automatic test_reset_values();
    send_word('0, 1'b0);
    send_word(VALUE_BITS'(1), 1'b1);
    send_word(VALUE_MAX, 1'b1);
    send_word(VALUE_BITS'(20'hAAAAA), 1'b0);
    send_word(VALUE_BITS'(20'h55555), 1'b1);
    drain_results();
  endtask

  // Zero exponent gives 1, zero base included
  task automatic test_zero_exponent();
    write_reg(mexp_pkg::REG_EXPONENT, '0);
    write_reg(mexp_pkg::REG_MODULUS, VALUE_MAX);
    send_word('0, 1'b0);
    send_word(VALUE_MAX, 1'b1);
    drain_results();
  endtask

  // Modulus written as 0 or 1 holds at 2
  task automatic test_modulus_saturation();
    write_reg(mexp_pkg::REG_EXPONENT, VALUE_MAX);
    write_reg(mexp_pkg::REG_MODULUS, '0);
    send_word(VALUE_BITS'(3), 1'b0);
    send_word(VALUE_MAX, 1'b1);
    drain_results();
    write_reg(mexp_pkg::REG_MODULUS, VALUE_BITS'(1));
    send_word(VALUE_BITS'(5), 1'b1);
    drain_results();
  endtask

  // Largest exponent and modulus
  task automatic test_extreme_operands();
    write_reg(mexp_pkg::REG_MODULUS, VALUE_MAX);
    send_word(VALUE_MAX - VALUE_BITS'(1), 1'b0);
    send_word(VALUE_BITS'(2), 1'b1);
    drain_results();
  endtask

  // Base at or above the modulus is reduced first
  task automatic test_base_reduction();
    write_reg(mexp_pkg::REG_EXPONENT, VALUE_BITS'(5));
    write_reg(mexp_pkg::REG_MODULUS, VALUE_BITS'(13));
    send_word(VALUE_BITS'(13), 1'b0);
    send_word(VALUE_BITS'(14), 1'b1);
    send_word(VALUE_MAX, 1'b0);
    drain_results();
  endtask

  // Writes to indexes past the register file change nothing
  task automatic test_unused_index();
    write_reg(REG_UNUSED_2, '0);
    write_reg(REG_UNUSED_3, VALUE_BITS'(1));
    send_word(VALUE_BITS'(2), 1'b1);
    drain_results();
  endtask

  // Small textbook key pair: n = 61 * 53, e = 17, d = 2753
  task automatic test_rsa_round_trip();
    write_reg(mexp_pkg::REG_MODULUS, VALUE_BITS'(3233));
    write_reg(mexp_pkg::REG_EXPONENT, VALUE_BITS'(17));
    send_word(VALUE_BITS'(65), 1'b0);
    send_word(VALUE_BITS'(3232), 1'b1);
    drain_results();
    write_reg(mexp_pkg::REG_EXPONENT, VALUE_BITS'(2753));
    send_word(VALUE_BITS'(2790), 1'b1);
    drain_results();
  endtask

  // Random settings between chunks, random words within, across the idling phases
  task automatic test_random_traffic();
    int words_left;
    int chunk;
    int ex_len;
    logic [VALUE_BITS-1:0] base;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      words_left = RANDOM_WORDS / 4;
      while (words_left > 0) begin
        chunk = $urandom_range(10, 40);
        if (chunk > words_left) chunk = words_left;
        drain_results();
        // new settings; short exponents are common to keep the run short
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(9))
            0: write_reg(mexp_pkg::REG_EXPONENT, '0);
            1: write_reg(mexp_pkg::REG_EXPONENT, VALUE_MAX);
            2: write_reg(mexp_pkg::REG_EXPONENT, VALUE_BITS'(1));
            default: begin
              ex_len = $urandom_range(1, VALUE_BITS);
              write_reg(mexp_pkg::REG_EXPONENT,
                        VALUE_BITS'($urandom) & (VALUE_MAX >> (VALUE_BITS - ex_len)));
            end
          endcase
        end
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(9))
            0: write_reg(mexp_pkg::REG_MODULUS, VALUE_BITS'($urandom_range(1)));
            1: write_reg(mexp_pkg::REG_MODULUS, VALUE_MAX);
            2: write_reg(mexp_pkg::REG_MODULUS, VALUE_BITS'(2));
            3: write_reg(mexp_pkg::REG_MODULUS, VALUE_BITS'($urandom_range(3, 64)));
            default: write_reg(mexp_pkg::REG_MODULUS,
                               VALUE_BITS'($urandom_range(2, VALUE_MAX)));
          endcase
        end
        if ($urandom_range(15) == 0)
          write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, VALUE_BITS'($urandom));
        for (int k = 0; k < chunk; k++) begin
          case ($urandom_range(7))
            0: base = '0;
            1: base = VALUE_MAX;
            2: base = modulus_setting - VALUE_BITS'(1);
            3: base = modulus_setting;
            4: base = VALUE_BITS'($urandom_range(0, modulus_setting - 1));
            default: base = VALUE_BITS'($urandom);
          endcase
          send_word(base, 1'($urandom_range(1)));
          if ($urandom_range(39) == 0) drain_results();
        end
        words_left -= chunk;
      end
    end
    drain_results();
  endtask

  // Main sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_word.valid = 1'b0;
    in_word.base_value = '0;
    in_word.last_in = 1'b0;
    exponent_setting = VALUE_BITS'(1);
    modulus_setting = VALUE_BITS'(2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_exponent();
    test_modulus_saturation();
    test_extreme_operands();
    test_base_reduction();
    test_unused_index();
    test_rsa_round_trip();
    test_random_traffic();

    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> modular_exponentiation_top.f
sv/mexp_pkg.sv
sv/mexp_if.sv
sv/mexp_dp.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation_top.sv
sv/mexp_checker.sv
tb/modular_exponentiation_top_tb.sv
